>>> hw/rtl/dvrt_pkg.sv
package dvrt_pkg;

    localparam int MAX_ROUTERS = 128;
    localparam int MAX_PORTS   = 16;
    localparam int DIST_BITS   = 16;
    localparam int RIDX_BITS   = $clog2(MAX_ROUTERS);
    localparam int PORT_BITS   = $clog2(MAX_PORTS);
    localparam int NV_DEPTH    = MAX_ROUTERS * MAX_PORTS;
    localparam int NV_BITS     = $clog2(NV_DEPTH);
    localparam int CFG_BITS    = 8;

    localparam logic signed [DIST_BITS-1:0] DIST_MAX  = {1'b0, {(DIST_BITS-1){1'b1}}};
    localparam logic signed [DIST_BITS-1:0] DIST_NONE = '1;

    typedef enum logic [1:0] {
        KIND_ENTRY = 2'd0,
        KIND_COST  = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_READ  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CFG_SELF_ID      = 2'd0,
        CFG_ROUTER_COUNT = 2'd1,
        CFG_PORT_COUNT   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]                  kind;
        logic [3:0]                  port;
        logic [6:0]                  dest_index;
        logic signed [15:0]          value;
        logic [6:0]                  sender;
        logic                        last;
    } in_item_t;

    typedef struct packed {
        logic                        changed;
        logic [3:0]                  next_port;
        logic signed [15:0]          distance;
        logic                        is_self;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_WRITE,
        ST_R_START,
        ST_P_ISSUE,
        ST_P_WAIT,
        ST_P_ACC,
        ST_R_OWN,
        ST_R_WRITE,
        ST_Q_OWN,
        ST_Q_WAIT,
        ST_Q_CHECK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic write_item;
        logic load_relax_all;
        logic load_relax_one;
        logic load_query;
        logic issue_port;
        logic accept_port;
        logic issue_own;
        logic relax_write;
        logic next_router;
        logic q_check;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic relax_needed;
        logic router_done;
        logic ports_done;
        logic skip_self;
    } sts_t;

    function automatic logic signed [DIST_BITS-1:0] norm_value(
        input logic signed [15:0] raw);
        logic signed [DIST_BITS-1:0] r;
        if (raw < 0)
            r = DIST_NONE;
        else if ($signed({1'b0, raw}) > $signed({1'b0, DIST_MAX}))
            r = DIST_MAX;
        else
            r = DIST_BITS'(raw);
        return r;
    endfunction

endpackage

>>> hw/rtl/distance_vector_route_table_unit.sv
// Distance-vector route table. Items are taken one at a time. A vector entry
// without last, a cost change on a port with no recorded neighbour, or one whose
// neighbour is this router, gives its result without recomputation. A query or read
// walks ports 2 to port_count through the neighbour-vector memory.
// A last entry runs recomputation over router_count routers (at most 128, skipping
// this router), each visiting ports 2 to port_count; a cost change relaxes only the
// neighbour router on that port. After reset a clearing pass sweeps all 2048 entries
// of the neighbour-vector memory before the first item is taken.
module distance_vector_route_table_unit
    import dvrt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  in_item_t            in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output out_item_t           out_item,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data
);

    in_item_t  item_reg;
    cmd_t      cmd;
    sts_t      sts;
    out_item_t result;

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            item_reg <= in_item;
    end

    dvrt_control u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .item      (item_reg),
        .sts       (sts),
        .out_stall (out_stall),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    dvrt_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_reg),
        .cmd       (cmd),
        .sts       (sts),
        .result    (result)
    );

    assign out_item = result;

endmodule

>>> hw/rtl/dvrt_ram.sv
module dvrt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/dvrt_datapath.sv
module dvrt_datapath
    import dvrt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [CFG_BITS-1:0]  cfg_data,
    input  in_item_t             item,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    output out_item_t            result
);

    logic [6:0]            self_id_reg;
    logic [7:0]            router_count_reg;
    logic [3:0]            port_count_reg;

    logic signed [DIST_BITS-1:0] cost_reg [MAX_PORTS];
    logic [RIDX_BITS-1:0]  nbr_reg [MAX_PORTS];
    logic [MAX_PORTS-1:0]  nbr_valid_reg;

    logic [NV_BITS-1:0]    clr_reg;
    logic [RIDX_BITS-1:0]  router_reg;
    logic [PORT_BITS:0]    port_reg;
    logic [PORT_BITS:0]    rport_reg;
    logic                  all_reg;
    logic                  found_reg;
    logic signed [DIST_BITS-1:0] best_reg;
    logic                  changed_reg;
    logic                  qmatch_reg;
    logic [3:0]            qport_reg;
    logic signed [DIST_BITS-1:0] qdist_reg;

    logic                  nv_we;
    logic [NV_BITS-1:0]    nv_waddr;
    logic [DIST_BITS-1:0]  nv_wdata;
    logic [NV_BITS-1:0]    nv_raddr;
    logic [DIST_BITS-1:0]  nv_rdata;

    logic                  own_we;
    logic [RIDX_BITS-1:0]  own_waddr;
    logic [DIST_BITS-1:0]  own_wdata;
    logic [RIDX_BITS-1:0]  own_raddr;
    logic [DIST_BITS-1:0]  own_rdata;
    logic [MAX_ROUTERS-1:0] own_valid_reg;

    logic signed [DIST_BITS-1:0] own_val;
    logic signed [DIST_BITS-1:0] nv_val;
    logic signed [DIST_BITS-1:0] cost_now;
    logic signed [DIST_BITS:0]   sum_wide;
    logic signed [DIST_BITS-1:0] sum_sat;
    logic                  path_ok;
    logic [PORT_BITS:0]    pc_eff;
    logic [8:0]            rc_eff;
    logic [PORT_BITS-1:0]  pidx;
    logic [PORT_BITS-1:0]  rpidx;

    dvrt_ram #(.WIDTH(DIST_BITS), .DEPTH(NV_DEPTH)) u_nv (
        .clk   (clk),
        .we    (nv_we),
        .waddr (nv_waddr),
        .wdata (nv_wdata),
        .raddr (nv_raddr),
        .rdata (nv_rdata)
    );

    dvrt_ram #(.WIDTH(DIST_BITS), .DEPTH(MAX_ROUTERS)) u_own (
        .clk   (clk),
        .we    (own_we),
        .waddr (own_waddr),
        .wdata (own_wdata),
        .raddr (own_raddr),
        .rdata (own_rdata)
    );

    assign pc_eff = (PORT_BITS+1)'(port_count_reg);
    assign rc_eff = ({1'b0, router_count_reg} > 9'(MAX_ROUTERS)) ? 9'(MAX_ROUTERS)
                                                              : {1'b0, router_count_reg};
    assign pidx   = port_reg[PORT_BITS-1:0];
    assign rpidx  = rport_reg[PORT_BITS-1:0];

    always_comb
    begin
        nv_we    = 1'b0;
        nv_waddr = clr_reg;
        nv_wdata = DIST_NONE;
        if (cmd.clear_step)
            nv_we = 1'b1;
        else if (cmd.write_item)
        begin
            nv_we    = 1'b1;
            nv_waddr = {item.port, item.dest_index};
            nv_wdata = norm_value(item.value);
        end
    end

    assign nv_raddr  = {pidx, router_reg};
    assign own_raddr = cmd.load_query ? item.dest_index : router_reg;
    assign own_val   = own_valid_reg[router_reg] ? $signed(own_rdata) : DIST_NONE;
    assign nv_val    = $signed(nv_rdata);
    assign cost_now  = cost_reg[rpidx];
    assign sum_wide  = $signed({1'b0, cost_now}) + $signed({1'b0, nv_val});
    assign sum_sat   = (sum_wide > $signed({1'b0, DIST_MAX})) ? DIST_MAX
                                                            : sum_wide[DIST_BITS-1:0];
    assign path_ok   = (cost_now >= 0) && (nv_val >= 0);

    always_comb
    begin
        own_we    = 1'b0;
        own_waddr = router_reg;
        own_wdata = best_reg;
        if (cfg_write && cfg_index == CFG_SELF_ID)
        begin
            own_we    = 1'b1;
            own_waddr = cfg_data[6:0];
            own_wdata = '0;
        end
        else if (cmd.clear_step && clr_reg == '0)
        begin
            own_we    = 1'b1;
            own_waddr = '0;
            own_wdata = '0;
        end
        else if (cmd.relax_write && found_reg)
            own_we = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_id_reg      <= '0;
            router_count_reg <= 8'd128;
            port_count_reg   <= 4'd15;
            nbr_valid_reg    <= '0;
            own_valid_reg    <= MAX_ROUTERS'(1);
            clr_reg          <= '0;
            for (int i = 0; i < MAX_PORTS; i++)
                cost_reg[i] <= (i == 0) ? '0 : DIST_NONE;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_SELF_ID:      self_id_reg      <= cfg_data[6:0];
                    CFG_ROUTER_COUNT: router_count_reg <= cfg_data;
                    CFG_PORT_COUNT:   port_count_reg   <= cfg_data[3:0];
                    default:          ;
                endcase
            end
            if (own_we)
                own_valid_reg[own_waddr] <= 1'b1;
            if (cmd.clear_step)
                clr_reg <= clr_reg + 1'b1;
            if (cmd.write_item)
            begin
                nbr_reg[item.port]       <= item.sender;
                nbr_valid_reg[item.port] <= 1'b1;
            end
            if (cmd.load_relax_one)
                cost_reg[item.port] <= norm_value(item.value);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_relax_all || cmd.load_query)
        begin
            router_reg  <= (cmd.load_query) ? item.dest_index : '0;
            all_reg     <= cmd.load_relax_all;
            changed_reg <= 1'b0;
            port_reg    <= (PORT_BITS+1)'(2);
            found_reg   <= 1'b0;
            qmatch_reg  <= 1'b0;
            qport_reg   <= 4'd1;
        end
        else if (cmd.load_relax_one)
        begin
            router_reg  <= nbr_reg[item.port];
            all_reg     <= 1'b0;
            changed_reg <= 1'b0;
            port_reg    <= (PORT_BITS+1)'(2);
            found_reg   <= 1'b0;
        end
        if (cmd.issue_port)
        begin
            rport_reg <= port_reg;
            port_reg  <= port_reg + 1'b1;
        end
        if (cmd.accept_port && path_ok && (!found_reg || sum_sat < best_reg))
        begin
            best_reg  <= sum_sat;
            found_reg <= 1'b1;
        end
        if (cmd.issue_own)
            qdist_reg <= own_val;
        if (cmd.relax_write)
        begin
            if (found_reg && own_val != best_reg)
                changed_reg <= 1'b1;
            router_reg <= router_reg + 1'b1;
            port_reg   <= (PORT_BITS+1)'(2);
            found_reg  <= 1'b0;
        end
        if (cmd.q_check && !qmatch_reg && path_ok && sum_sat == qdist_reg)
        begin
            qmatch_reg <= 1'b1;
            qport_reg  <= rpidx;
        end
    end

    always_comb
    begin
        sts.clear_done   = (clr_reg == NV_BITS'(NV_DEPTH - 1));
        sts.relax_needed = nbr_valid_reg[item.port] && nbr_reg[item.port] != self_id_reg;
        sts.router_done  = !all_reg || ({2'b0, router_reg} + 9'd1 >= rc_eff)
                           || (router_reg == RIDX_BITS'(MAX_ROUTERS - 1));
        sts.ports_done   = (port_reg > pc_eff);
        sts.skip_self    = all_reg && (router_reg == self_id_reg);
    end

    always_comb
    begin
        result.changed   = changed_reg;
        result.is_self   = 1'b0;
        result.distance  = '0;
        result.next_port = '0;
        if (item.kind == KIND_QUERY || item.kind == KIND_READ)
        begin
            result.is_self  = (item.dest_index == self_id_reg);
            result.distance = qdist_reg;
            result.changed  = 1'b0;
            if (item.kind == KIND_QUERY && !result.is_self)
                result.next_port = (qdist_reg >= 0) ? qport_reg : 4'd1;
        end
        else if (item.kind == KIND_ENTRY && !item.last)
            result.changed = 1'b0;
        else if (item.kind == KIND_COST && !sts.relax_needed)
            result.changed = 1'b0;
    end

endmodule

>>> hw/rtl/dvrt_control.sv
module dvrt_control
    import dvrt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  in_item_t item,
    input  sts_t     sts,
    input  logic     out_stall,
    output logic     in_stall,
    output logic     out_valid,
    output cmd_t     cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:   if (sts.clear_done) state_next = ST_IDLE;
            ST_IDLE:    if (in_valid) state_next = ST_WRITE;
            ST_WRITE:
            begin
                priority case (1'b1)
                    item.kind == KIND_ENTRY && item.last:          state_next = ST_R_START;
                    item.kind == KIND_COST && sts.relax_needed:   state_next = ST_R_START;
                    item.kind == KIND_QUERY || item.kind == KIND_READ:
                                                                  state_next = ST_Q_OWN;
                    default:                                      state_next = ST_DONE;
                endcase
            end
            ST_R_START: state_next = sts.skip_self ? ST_R_WRITE : ST_P_ISSUE;
            ST_P_ISSUE: state_next = sts.ports_done ? ST_R_OWN : ST_P_WAIT;
            ST_P_WAIT:  state_next = ST_P_ACC;
            ST_P_ACC:   state_next = ST_P_ISSUE;
            ST_R_OWN:   state_next = ST_R_WRITE;
            ST_R_WRITE: state_next = sts.router_done ? ST_DONE : ST_R_START;
            ST_Q_OWN:   state_next = ST_Q_WAIT;
            ST_Q_WAIT:  state_next = sts.ports_done ? ST_DONE : ST_Q_CHECK;
            ST_Q_CHECK: state_next = ST_Q_WAIT;
            ST_DONE:    if (!out_stall) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_CLEAR:   cmd.clear_step = 1'b1;
            ST_IDLE:    in_stall = 1'b0;
            ST_WRITE:
            begin
                cmd.write_item     = (item.kind == KIND_ENTRY);
                cmd.load_relax_all = (item.kind == KIND_ENTRY);
                cmd.load_relax_one = (item.kind == KIND_COST);
                cmd.load_query     = (item.kind == KIND_QUERY || item.kind == KIND_READ);
            end
            ST_R_START: ;
            ST_P_ISSUE: cmd.issue_port = !sts.ports_done;
            ST_P_WAIT:  cmd.accept_port = 1'b1;
            ST_P_ACC:   ;
            ST_R_OWN:   ;
            ST_R_WRITE: cmd.relax_write = 1'b1;
            ST_Q_OWN:   cmd.issue_own = 1'b1;
            ST_Q_WAIT:  cmd.issue_port = !sts.ports_done;
            ST_Q_CHECK: cmd.q_check = 1'b1;
            ST_DONE:    out_valid = 1'b1;
            default:    ;
        endcase
    end

endmodule

>>> hw/rtl/dvrt_checker.sv
module dvrt_checker
    import dvrt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_item_t out_item
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken before result");

    a_no_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while result pending");

    a_self_port: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.is_self |-> out_item.next_port == 4'd0)
        else $error("next port given for self");

endmodule

bind distance_vector_route_table_unit dvrt_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

>>> tb/sv/tb_distance_vector_route_table_unit.sv
module tb_distance_vector_route_table_unit
    import dvrt_pkg::*;
();

    localparam int WATCH_LIMIT = 60000;
    localparam int SETTLE      = 64;

    class route_table_scoreboard;
        logic signed [15:0] nbr_dist [16][128];
        logic signed [15:0] own_dist [128];
        logic signed [15:0] link_cost [16];
        logic [6:0]         nbr_id [16];
        bit                 nbr_known [16];
        int unsigned        self_id;
        int unsigned        router_count;
        int unsigned        port_count;
        out_item_t          pending [$];
        int                 errors;
        int                 results;
        int                 items;

        function void reset_state();
            for (int p = 0; p < 16; p++) begin
                for (int r = 0; r < 128; r++)
                    nbr_dist[p][r] = DIST_NONE;
                link_cost[p] = DIST_NONE;
                nbr_id[p] = '0;
                nbr_known[p] = 0;
            end
            for (int r = 0; r < 128; r++)
                own_dist[r] = DIST_NONE;
            link_cost[0] = '0;
            self_id = 0;
            router_count = 128;
            port_count = 15;
            own_dist[0] = '0;
            errors = 0;
            results = 0;
            items = 0;
        endfunction

        function void set_register(cfg_index_t idx, logic [7:0] data);
            case (idx)
                CFG_SELF_ID:
                begin
                    self_id = data[6:0];
                    own_dist[self_id] = '0;
                end
                CFG_ROUTER_COUNT: router_count = data;
                CFG_PORT_COUNT:   port_count = data[3:0];
                default: ;
            endcase
        endfunction

        function int path_cost(int p, int r);
            int c;
            int d;
            int s;
            c = link_cost[p];
            d = nbr_dist[p][r];
            if (c < 0 || d < 0)
                return -1;
            s = c + d;
            return (s > 32767) ? 32767 : s;
        endfunction

        function bit relax_router(int r);
            int pc;
            int best;
            int s;
            bit hit;
            pc = (port_count > 15) ? 15 : port_count;
            hit = 0;
            best = 0;
            for (int i = 2; i <= pc; i++) begin
                s = path_cost(i, r);
                if (s >= 0 && (!hit || s < best))
                begin
                    best = s;
                    hit = 1;
                end
            end
            if (!hit)
                return 0;
            if (own_dist[r] != 16'(best))
            begin
                own_dist[r] = 16'(best);
                return 1;
            end
            return 0;
        endfunction

        function void note(in_item_t it);
            out_item_t res;
            logic signed [15:0] val;
            int rc;
            int pc;
            res = '0;
            items++;
            val = (it.value < 0) ? DIST_NONE : it.value;
            case (kind_t'(it.kind))
                KIND_ENTRY:
                begin
                    nbr_dist[it.port][it.dest_index] = val;
                    nbr_id[it.port] = it.sender;
                    nbr_known[it.port] = 1;
                    if (it.last)
                    begin
                        rc = (router_count > 128) ? 128 : router_count;
                        for (int r = 0; r < rc; r++)
                            if (r != self_id && relax_router(r))
                                res.changed = 1;
                    end
                end
                KIND_COST:
                begin
                    link_cost[it.port] = val;
                    if (nbr_known[it.port] && nbr_id[it.port] != self_id)
                        res.changed = relax_router(nbr_id[it.port]);
                end
                default:
                begin
                    res.is_self = (it.dest_index == self_id);
                    res.distance = own_dist[it.dest_index];
                    if (it.kind == KIND_QUERY && !res.is_self)
                    begin
                        res.next_port = 4'd1;
                        if (res.distance >= 0)
                        begin
                            pc = (port_count > 15) ? 15 : port_count;
                            for (int i = 2; i <= pc; i++)
                                if (path_cost(i, it.dest_index) == int'(res.distance))
                                begin
                                    res.next_port = 4'(i);
                                    break;
                                end
                        end
                    end
                end
            endcase
            pending.push_back(res);
        endfunction

        task report(string what, int got, int want);
            errors++;
            if (errors <= 30)
                $display("MISMATCH result %0d %s: got %0d expected %0d",
                         results, what, got, want);
        endtask

        task check(out_item_t got);
            out_item_t want;
            results++;
            if (pending.size() == 0)
            begin
                report("unexpected item", 1, 0);
                return;
            end
            want = pending.pop_front();
            if (got.changed != want.changed)
                report("changed", got.changed, want.changed);
            if (got.next_port != want.next_port)
                report("next_port", got.next_port, want.next_port);
            if (got.distance !== want.distance)
                report("distance", got.distance, want.distance);
            if (got.is_self != want.is_self)
                report("is_self", got.is_self, want.is_self);
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_item_t   in_item;
    logic       out_valid;
    logic       out_stall;
    out_item_t  out_item;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    route_table_scoreboard sb;
    bit quiet;
    int hold_count;
    int idle_cycles;
    int cur_rc;
    int cur_pc;
    int lasts_sent;

    distance_vector_route_table_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note(in_item);
            if (out_valid && !out_stall)
            begin
                sb.check(out_item);
                hold_count = quiet ? 0 : $urandom_range(0, 19);
            end
            if (hold_count > 0)
            begin
                out_stall <= 1'b1;
                hold_count--;
            end
            else
                out_stall <= 1'b0;
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCH_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", WATCH_LIMIT);
                $display("distance_vector_route_table_unit verification failed");
                $finish;
            end
        end
    end

    task send_item(in_item_t it);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        if (it.kind == KIND_ENTRY && it.last)
            lasts_sent++;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task write_reg(cfg_index_t idx, logic [7:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_register(idx, data);
        cur_rc = (sb.router_count > 128) ? 128 : sb.router_count;
        cur_pc = sb.port_count;
    endtask

    function automatic logic signed [15:0] pick_value();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 12)
            return 16'($urandom_range(0, 40));
        else if (sel < 14)
            return DIST_NONE;
        else if (sel < 15)
            return DIST_MAX;
        else if (sel < 16)
            return 16'($urandom_range(32700, 32767));
        return 16'($urandom);
    endfunction

    function automatic logic [6:0] pick_router();
        if ($urandom_range(0, 9) == 0)
            return 7'($urandom);
        return 7'($urandom_range(0, cur_rc - 1));
    endfunction

    function automatic logic [3:0] pick_port();
        if ($urandom_range(0, 7) == 0 || cur_pc < 2)
            return 4'($urandom);
        return 4'($urandom_range(2, cur_pc));
    endfunction

    function automatic in_item_t make_item(kind_t k, logic [3:0] p, logic [6:0] d,
                                           logic signed [15:0] v, logic [6:0] s,
                                           logic l);
        in_item_t it;
        it.kind = k;
        it.port = p;
        it.dest_index = d;
        it.value = v;
        it.sender = s;
        it.last = l;
        return it;
    endfunction

    task send_vector(int len);
        logic [3:0] p;
        logic [6:0] s;
        p = pick_port();
        s = pick_router();
        for (int i = 0; i < len; i++)
            send_item(make_item(KIND_ENTRY, p, pick_router(), pick_value(), s,
                                i == len - 1));
    endtask

    task random_phase(int count, int last_cap);
        int sel;
        int n;
        n = 0;
        while (n < count)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 30 && lasts_sent < last_cap)
            begin
                send_vector($urandom_range(1, (cur_rc < 6) ? cur_rc : 6));
                n += 3;
            end
            else if (sel < 45)
                send_item(make_item(KIND_COST, pick_port(), 7'($urandom), pick_value(),
                                    7'($urandom), 1'($urandom)));
            else if (sel < 70)
                send_item(make_item(KIND_QUERY, 4'($urandom), pick_router(),
                                    16'($urandom), 7'($urandom), 1'($urandom)));
            else if (sel < 82)
                send_item(make_item(KIND_READ, 4'($urandom), pick_router(),
                                    16'($urandom), 7'($urandom), 1'($urandom)));
            else
                send_item(make_item(KIND_ENTRY, 4'($urandom), pick_router(), pick_value(),
                                    7'($urandom), 1'b0));
            n++;
            if (n == count / 2)
                drain();
        end
        drain();
    endtask

    task config_phase(logic [7:0] self_v, logic [7:0] rc, logic [7:0] pc);
        write_reg(CFG_SELF_ID, self_v);
        write_reg(CFG_ROUTER_COUNT, rc);
        write_reg(CFG_PORT_COUNT, pc);
    endtask

    initial
    begin
        sb = new();
        sb.reset_state();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        quiet = 0;
        hold_count = 0;
        idle_cycles = 0;
        lasts_sent = 0;
        cur_rc = 128;
        cur_pc = 15;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(make_item(KIND_READ, 4'd0, 7'd0, 16'sd0, 7'd0, 1'b0));
        drain();
        config_phase(8'd3, 8'd8, 8'd4);
        send_item(make_item(KIND_QUERY, 4'd0, 7'd3, 16'sd0, 7'd0, 1'b0));
        send_item(make_item(KIND_COST, 4'd2, 7'd0, 16'sd5, 7'd0, 1'b0));
        send_item(make_item(KIND_COST, 4'd3, 7'd0, 16'sd1, 7'd0, 1'b0));
        send_item(make_item(KIND_COST, 4'd4, 7'd0, DIST_MAX, 7'd0, 1'b0));
        send_item(make_item(KIND_ENTRY, 4'd2, 7'd1, 16'sd0, 7'd1, 1'b0));
        send_item(make_item(KIND_ENTRY, 4'd2, 7'd5, 16'sd7, 7'd1, 1'b1));
        send_item(make_item(KIND_ENTRY, 4'd3, 7'd1, -16'sd300, 7'd3, 1'b0));
        send_item(make_item(KIND_ENTRY, 4'd3, 7'd5, 16'sd1, 7'd3, 1'b1));
        send_item(make_item(KIND_ENTRY, 4'd4, 7'd6, DIST_MAX, 7'd127, 1'b1));
        send_item(make_item(KIND_ENTRY, 4'd1, 7'd7, 16'sd0, 7'd7, 1'b1));
        send_item(make_item(KIND_ENTRY, 4'd15, 7'd127, 16'sh7fff, 7'd127, 1'b0));
        send_item(make_item(KIND_QUERY, 4'd0, 7'd5, 16'sd0, 7'd0, 1'b0));
        send_item(make_item(KIND_QUERY, 4'd0, 7'd6, 16'sd0, 7'd0, 1'b0));
        send_item(make_item(KIND_QUERY, 4'd0, 7'd7, 16'sd0, 7'd0, 1'b0));
        send_item(make_item(KIND_QUERY, 4'd15, 7'd127, 16'sd0, 7'd127, 1'b1));
        send_item(make_item(KIND_COST, 4'd3, 7'd0, DIST_NONE, 7'd0, 1'b0));
        send_item(make_item(KIND_COST, 4'd2, 7'd0, 16'sd1, 7'd0, 1'b0));
        send_item(make_item(KIND_COST, 4'd0, 7'd0, 16'sd9, 7'd0, 1'b0));
        send_item(make_item(KIND_READ, 4'd0, 7'd5, 16'sd0, 7'd0, 1'b0));
        send_item(make_item(KIND_READ, 4'd0, 7'd127, 16'sd0, 7'd0, 1'b0));
        drain();

        random_phase(400, 60);
        config_phase(8'd1, 8'd16, 8'd15);
        quiet = 1;
        random_phase(300, 110);
        quiet = 0;
        config_phase(8'd0, 8'd1, 8'd1);
        random_phase(200, 160);
        config_phase(8'd127, 8'd255, 8'd0);
        random_phase(150, 190);
        config_phase(8'd64, 8'd128, 8'd15);
        random_phase(60, 198);
        config_phase(8'd5, 8'd12, 8'd7);
        random_phase(500, 280);
        config_phase(8'd2, 8'd4, 8'd3);
        quiet = 1;
        random_phase(150, 320);
        quiet = 0;
        random_phase(250, 360);

        $display("covered %0d items and %0d results over seven register settings",
                 sb.items, sb.results);
        $display("%0d vectors closed, %0d mismatches", lasts_sent, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("distance_vector_route_table_unit verification clean");
        else
            $display("distance_vector_route_table_unit verification failed");
        $finish;
    end

endmodule
